>>> rtl/core/afd_pkg.sv
// afd_pkg: types and constants shared by the frame deframer and its checker.
// No dependencies.

package afd_pkg;

  localparam int unsigned CFG_IDX_W = 2;

  localparam logic [7:0]  DELIM_RESET  = 8'd126;
  localparam logic [7:0]  RETRY_RESET  = 8'd10;
  localparam logic [7:0]  SUM_GOOD     = 8'hFF;
  localparam logic [7:0]  TICK_MAX     = 8'hFF;
  localparam logic [15:0] SHORT_LEN    = 16'd3;   // L below this: under 3 data bytes
  localparam logic [15:0] MSG_OFFSET   = 16'd2;   // type and source precede the message

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_START_DELIM = 2'd0,
    REG_RETRY_LIMIT = 2'd1
  } reg_idx_t;

  typedef enum logic [1:0] {
    PH_HUNT   = 2'd0,
    PH_LEN_HI = 2'd1,
    PH_LEN_LO = 2'd2,
    PH_BODY   = 2'd3
  } phase_t;

  typedef enum logic [2:0] {
    KIND_MSG     = 3'd0,
    KIND_GOOD    = 3'd1,
    KIND_BADSUM  = 3'd2,
    KIND_SHORT   = 3'd3,
    KIND_TIMEOUT = 3'd4
  } kind_t;

  typedef struct packed {
    logic       command;
    logic [7:0] data_byte;
  } in_item_t;

  typedef struct packed {
    kind_t       kind;
    logic [7:0]  message_byte;
    logic [15:0] byte_index;
    logic [7:0]  frm_type;
    logic [7:0]  src_iface;
    logic [15:0] msg_len;
  } out_item_t;

endpackage

>>> rtl/core/api_frame_deframer.sv
// api_frame_deframer: serial frame deframer with streaming message output.
// Depends on afd_pkg.
//
//  channel | direction | handshake            | payload
//  --------+-----------+----------------------+-----------------------------
//  in_     | input     | in_valid / in_stall  | in_item  (command, data_byte)
//  out_    | output    | out_valid / out_stall| out_item (kind .. length)
//  cfg_    | input     | cfg_valid / cfg_ready| cfg_index, cfg_data
//
// One request per cycle while in_stall is low; each request is decoded against
// the frame state in a single combinational pass and its result, if any, is
// loaded into the output register when the request is accepted.
// The output register is the only buffer: in_stall rises only while a held
// result is stalled, so a new request is taken in the cycle a result drains.
// rst_n is synchronous; it returns the deframer to hunting, empties the
// output register and restores delimiter 126 and retry limit 10.
// cfg_ready is always high.

module api_frame_deframer (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  afd_pkg::in_item_t              in_item,
  output logic                           out_valid,
  input  logic                           out_stall,
  output afd_pkg::out_item_t             out_item,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [afd_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [7:0]                     cfg_data
);
  import afd_pkg::*;

  // configuration
  logic [7:0] start_delim_r;
  logic [7:0] retry_limit_r;

  // frame state
  phase_t      phase_r, phase_nxt;
  logic [15:0] frame_len_r, frame_len_nxt;
  logic [15:0] pos_r, pos_nxt;
  logic [7:0]  sum_r, sum_nxt;
  logic [7:0]  ticks_r, ticks_nxt;
  logic [7:0]  type_r, type_nxt;
  logic [7:0]  src_r, src_nxt;

  // output register
  logic      out_valid_r;
  out_item_t out_item_r;

  logic      res_valid;
  out_item_t res;

  logic        accept;
  logic        tick;
  logic [7:0]  rx;
  logic        delim_hit;
  logic [7:0]  ticks_inc;
  logic        timeout_hit;
  logic        body_last;
  logic [7:0]  sum_add;

  assign in_stall  = out_valid_r & out_stall;
  assign accept    = in_valid & ~in_stall;
  assign cfg_ready = 1'b1;
  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

  assign tick        = in_item.command;
  assign rx          = in_item.data_byte;
  assign delim_hit   = ~tick && (rx == start_delim_r);
  assign ticks_inc   = (ticks_r == TICK_MAX) ? TICK_MAX : ticks_r + 8'd1;
  assign timeout_hit = ticks_inc >= retry_limit_r;
  // last data byte (the checksum) when this byte's position reaches L
  assign body_last   = pos_r >= frame_len_r;
  assign sum_add     = sum_r + rx;

  // next phase
  always_comb begin
    phase_nxt = phase_r;
    unique case (phase_r)
      PH_HUNT: begin
        if (delim_hit) phase_nxt = PH_LEN_HI;
      end
      PH_LEN_HI: begin
        if (tick) begin
          if (timeout_hit) phase_nxt = PH_HUNT;
        end else begin
          phase_nxt = PH_LEN_LO;
        end
      end
      PH_LEN_LO: begin
        if (tick) begin
          if (timeout_hit) phase_nxt = PH_HUNT;
        end else begin
          phase_nxt = PH_BODY;
        end
      end
      PH_BODY: begin
        if (tick) begin
          if (timeout_hit) phase_nxt = PH_HUNT;
        end else if (body_last) begin
          phase_nxt = PH_HUNT;
        end
      end
      default: phase_nxt = PH_HUNT;
    endcase
  end

  // datapath and result
  always_comb begin
    frame_len_nxt = frame_len_r;
    pos_nxt       = pos_r;
    sum_nxt       = sum_r;
    ticks_nxt     = ticks_r;
    type_nxt      = type_r;
    src_nxt       = src_r;
    res_valid     = 1'b0;
    res           = '0;
    res.kind      = KIND_MSG;

    if (phase_r == PH_HUNT) begin
      if (delim_hit) begin
        frame_len_nxt = '0;
        pos_nxt       = '0;
        sum_nxt       = '0;
        ticks_nxt     = '0;
        type_nxt      = '0;
        src_nxt       = '0;
      end
    end else if (tick) begin
      ticks_nxt = ticks_inc;
      if (timeout_hit) begin
        res_valid     = 1'b1;
        res.kind      = KIND_TIMEOUT;
        res.frm_type  = type_r;
        res.src_iface = src_r;
      end
    end else begin
      unique case (phase_r)
        PH_LEN_HI: frame_len_nxt = {rx, 8'h00};
        PH_LEN_LO: begin
          frame_len_nxt = {frame_len_r[15:8], rx};
          ticks_nxt     = '0;
          pos_nxt       = '0;
        end
        default: begin
          // body byte
          sum_nxt = sum_add;
          pos_nxt = pos_r + 16'd1;
          if (pos_r == 16'd0) type_nxt = rx;
          if (pos_r == 16'd1) src_nxt  = rx;
          if (body_last) begin
            res_valid     = 1'b1;
            res.frm_type  = (pos_r == 16'd0) ? rx : type_r;
            res.src_iface = (pos_r == 16'd1) ? rx : src_r;
            if (frame_len_r < SHORT_LEN) begin
              res.kind = KIND_SHORT;
            end else begin
              res.kind    = (sum_add == SUM_GOOD) ? KIND_GOOD : KIND_BADSUM;
              res.msg_len = frame_len_r - MSG_OFFSET;
            end
          end else if (pos_r >= MSG_OFFSET) begin
            res_valid        = 1'b1;
            res.kind         = KIND_MSG;
            res.message_byte = rx;
            res.byte_index   = pos_r - MSG_OFFSET;
          end
        end
      endcase
    end
  end

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      start_delim_r <= DELIM_RESET;
      retry_limit_r <= RETRY_RESET;
    end else if (cfg_valid && cfg_ready) begin
      if (cfg_index == REG_START_DELIM) start_delim_r <= cfg_data;
      if (cfg_index == REG_RETRY_LIMIT) retry_limit_r <= cfg_data;
    end
  end

  // frame state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= PH_HUNT;
      frame_len_r <= '0;
      pos_r       <= '0;
      sum_r       <= '0;
      ticks_r     <= '0;
      type_r      <= '0;
      src_r       <= '0;
    end else if (accept) begin
      phase_r     <= phase_nxt;
      frame_len_r <= frame_len_nxt;
      pos_r       <= pos_nxt;
      sum_r       <= sum_nxt;
      ticks_r     <= ticks_nxt;
      type_r      <= type_nxt;
      src_r       <= src_nxt;
    end
  end

  // output register: loaded on every accepted request, cleared when drained
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (accept) begin
      out_valid_r <= res_valid;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      out_item_r <= res;
    end
  end

endmodule

>>> rtl/core/afd_checker.sv
// afd_checker: port-level assertions for api_frame_deframer, bound to the top.
// Depends on afd_pkg and api_frame_deframer.

module afd_checker (
  input logic                           clk,
  input logic                           rst_n,
  input logic                           in_valid,
  input logic                           in_stall,
  input logic                           out_valid,
  input logic                           out_stall,
  input afd_pkg::out_item_t             out_item
);
  import afd_pkg::*;

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_item))
    else $error("stalled result changed or dropped");

  // the input stalls only behind a stalled result
  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> out_valid && out_stall)
    else $error("input stalled without a held result");

  // no result appears without an accepted request
  a_no_invent: assert property (@(posedge clk) disable iff (!rst_n)
    !(in_valid && !in_stall) && !(out_valid && out_stall) |=> !out_valid)
    else $error("result without a request");

  // message bytes carry no frame summary; final results carry no byte
  a_field_split: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_item.kind == KIND_MSG)
      ? (out_item.frm_type == 8'd0 && out_item.src_iface == 8'd0
         && out_item.msg_len == 16'd0)
      : (out_item.message_byte == 8'd0 && out_item.byte_index == 16'd0))
    else $error("result fields inconsistent with kind");

  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid after reset");

endmodule

bind api_frame_deframer afd_checker u_afd_checker (.*);
